// ===== hw/rtl/tiloc_pkg.sv =====
// ----------------------------------------------------------------------------
// tiloc_pkg
// shared constants and codes of the timed interval locator
// ----------------------------------------------------------------------------
package tiloc_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_TIME_WIDTH  = 32;

  // width of the signed step offset of a seek item
  localparam int OFS_W = 12;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_LOCATE = 2'd1,
    OP_SEEK   = 2'd2
  } op_t;

endpackage

// ===== hw/rtl/timed_interval_locator_core.sv =====
// ----------------------------------------------------------------------------
// timed_interval_locator_core
// sorted interval table with forward-scan and binary-search lookup
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; every item gives
// exactly one result, shown for a single cycle with out_valid high, and the
// receiver cannot stall it, so it must take each result in that cycle.
// write items, items with the unused op code and items on an empty table
// finish at once, with the result in the next cycle. a locate or seek first
// reads the last entry (finish time), then either scans forward one entry per
// cycle from the remembered hit, or runs a binary search in which each halving
// step reads the middle entry, then compares it; a seek may then read the
// target entry. the table has a single read port. the user is to write
// entry_count through the cfg channel only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module timed_interval_locator_core #(
  parameter int TABLE_DEPTH = tiloc_pkg::DEF_TABLE_DEPTH,
  parameter int TIME_WIDTH  = tiloc_pkg::DEF_TIME_WIDTH,
  localparam int IDX_W      = $clog2(TABLE_DEPTH),
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration: entry count
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CNT_W-1:0]                   cfg_data,
  // item channel
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_op,
  input  logic [IDX_W-1:0]                   in_entry_index,
  input  logic [TIME_WIDTH-1:0]              in_entry_start,
  input  logic [TIME_WIDTH-1:0]              in_entry_end,
  input  logic [TIME_WIDTH-1:0]              in_query_time,
  input  logic                               in_seek_happened,
  input  logic signed [tiloc_pkg::OFS_W-1:0] in_step_offset,
  // result channel
  output logic                               out_valid,
  output logic                               out_found,
  output logic [IDX_W-1:0]                   out_hit_index,
  output logic [TIME_WIDTH-1:0]              out_target_time
);

  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        live_cnt;

  // table port signals
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [2*TIME_WIDTH-1:0] ram_wdata;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [2*TIME_WIDTH-1:0] ram_rdata;

  // entry count register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cnt_r <= cfg_data;
    end
  end

  // a count beyond the table acts as a full table
  assign live_cnt = (cnt_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cnt_r;

  // start and end of each entry share one word
  tiloc_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W),
    .DW    (2 * TIME_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // lookup sequencer, holds the remembered hit
  tiloc_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_entry_index   (in_entry_index),
    .in_entry_start   (in_entry_start),
    .in_entry_end     (in_entry_end),
    .in_query_time    (in_query_time),
    .in_seek_happened (in_seek_happened),
    .in_step_offset   (in_step_offset),
    .live_cnt         (live_cnt),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_hit_index    (out_hit_index),
    .out_target_time  (out_target_time)
  );

endmodule

// ===== hw/rtl/tiloc_ram.sv =====
// ----------------------------------------------------------------------------
// tiloc_ram
// interval table, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module tiloc_ram #(
  parameter int DEPTH = tiloc_pkg::DEF_TABLE_DEPTH,
  parameter int AW    = $clog2(tiloc_pkg::DEF_TABLE_DEPTH),
  parameter int DW    = 2 * tiloc_pkg::DEF_TIME_WIDTH
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tiloc_seq.sv =====
// ----------------------------------------------------------------------------
// tiloc_seq
// sequencer: table writes, forward scan, binary search and seek resolve
// ----------------------------------------------------------------------------
module tiloc_seq #(
  parameter int TABLE_DEPTH = tiloc_pkg::DEF_TABLE_DEPTH,
  parameter int TIME_WIDTH  = tiloc_pkg::DEF_TIME_WIDTH,
  parameter int IDX_W       = $clog2(tiloc_pkg::DEF_TABLE_DEPTH),
  parameter int CNT_W       = $clog2(tiloc_pkg::DEF_TABLE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_op,
  input  logic [IDX_W-1:0]               in_entry_index,
  input  logic [TIME_WIDTH-1:0]          in_entry_start,
  input  logic [TIME_WIDTH-1:0]          in_entry_end,
  input  logic [TIME_WIDTH-1:0]          in_query_time,
  input  logic                           in_seek_happened,
  input  logic signed [tiloc_pkg::OFS_W-1:0] in_step_offset,
  input  logic [CNT_W-1:0]               live_cnt,
  output logic                           ram_we,
  output logic [IDX_W-1:0]               ram_waddr,
  output logic [2*TIME_WIDTH-1:0]        ram_wdata,
  output logic                           ram_re,
  output logic [IDX_W-1:0]               ram_raddr,
  input  logic [2*TIME_WIDTH-1:0]        ram_rdata,
  output logic                           out_valid,
  output logic                           out_found,
  output logic [IDX_W-1:0]               out_hit_index,
  output logic [TIME_WIDTH-1:0]          out_target_time
);

  localparam int OFS_W = tiloc_pkg::OFS_W;
  localparam int TGT_W = ((IDX_W > OFS_W) ? IDX_W : OFS_W) + 2;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_FIN     = 8'b0000_0010,
    ST_SCAN    = 8'b0000_0100,
    ST_BIN_RD  = 8'b0000_1000,
    ST_BIN     = 8'b0001_0000,
    ST_CHK     = 8'b0010_0000,
    ST_SEEK    = 8'b0100_0000,
    ST_SEEK_RD = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  tiloc_pkg::op_t          op_r, op_nxt;
  logic [TIME_WIDTH-1:0]   t_r, t_nxt;
  logic                    seek_r, seek_nxt;
  logic signed [OFS_W-1:0] ofs_r, ofs_nxt;
  logic [TIME_WIDTH-1:0]   fin_r, fin_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        lo_r, lo_nxt;
  logic [IDX_W-1:0]        hi_r, hi_nxt;
  logic                    hit_r, hit_nxt;
  logic [IDX_W-1:0]        last_r, last_nxt;
  logic                    last_vld_r, last_vld_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic [TIME_WIDTH-1:0]   out_tgt_r, out_tgt_nxt;

  logic [TIME_WIDTH-1:0]   rd_start, rd_end;
  logic                    holds;
  logic [IDX_W-1:0]        last_addr;
  logic [IDX_W-1:0]        mid;
  logic [CNT_W-1:0]        scan_next;
  logic signed [TGT_W-1:0] tgt;
  logic                    done_loc, done_hit;
  logic [IDX_W-1:0]        done_idx;

  assign rd_start  = ram_rdata[2*TIME_WIDTH-1:TIME_WIDTH];
  assign rd_end    = ram_rdata[TIME_WIDTH-1:0];
  assign holds     = (t_r >= rd_start) && (t_r <= rd_end);
  assign last_addr = IDX_W'(live_cnt - CNT_W'(1));
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign scan_next = CNT_W'(idx_r) + CNT_W'(1);
  assign tgt       = $signed(hit_r ? TGT_W'(idx_r) : {TGT_W{1'b1}}) + TGT_W'(ofs_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    t_nxt         = t_r;
    seek_nxt      = seek_r;
    ofs_nxt       = ofs_r;
    fin_nxt       = fin_r;
    idx_nxt       = idx_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    hit_nxt       = hit_r;
    last_nxt      = last_r;
    last_vld_nxt  = last_vld_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    out_tgt_nxt   = out_tgt_r;
    ram_we        = 1'b0;
    ram_waddr     = in_entry_index;
    ram_wdata     = {in_entry_start, in_entry_end};
    ram_re        = 1'b0;
    ram_raddr     = '0;
    done_loc      = 1'b0;
    done_hit      = 1'b0;
    done_idx      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt   = tiloc_pkg::op_t'(in_op);
          t_nxt    = in_query_time;
          seek_nxt = in_seek_happened;
          ofs_nxt  = in_step_offset;
          if ((in_op == tiloc_pkg::OP_LOCATE || in_op == tiloc_pkg::OP_SEEK)
              && live_cnt != '0) begin
            ram_re    = 1'b1;
            ram_raddr = last_addr;
            state_nxt = ST_FIN;
          end else begin
            // writes, empty table and the unused code finish at once
            ram_we = (in_op == tiloc_pkg::OP_WRITE) &&
                     ({1'b0, in_entry_index} < (IDX_W+1)'(TABLE_DEPTH));
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_idx_nxt   = '0;
            out_tgt_nxt   = '0;
          end
        end
      end
      ST_FIN: begin
        fin_nxt = rd_end;
        if (t_r >= rd_end) begin
          done_loc = 1'b1;
          done_hit = 1'b1;
          done_idx = last_addr;
        end else if (op_r == tiloc_pkg::OP_LOCATE && last_vld_r && !seek_r) begin
          if (CNT_W'(last_r) < live_cnt) begin
            idx_nxt   = last_r;
            ram_re    = 1'b1;
            ram_raddr = last_r;
            state_nxt = ST_SCAN;
          end else begin
            done_loc = 1'b1;
          end
        end else begin
          lo_nxt    = '0;
          hi_nxt    = last_addr;
          state_nxt = ST_BIN_RD;
        end
      end
      ST_SCAN: begin
        if (holds) begin
          done_loc = 1'b1;
          done_hit = 1'b1;
          done_idx = idx_r;
        end else if (scan_next >= live_cnt) begin
          done_loc = 1'b1;
        end else begin
          idx_nxt   = IDX_W'(scan_next);
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(scan_next);
        end
      end
      ST_BIN_RD: begin
        ram_re = 1'b1;
        if (lo_r < hi_r) begin
          ram_raddr = mid;
          idx_nxt   = mid;
          state_nxt = ST_BIN;
        end else begin
          ram_raddr = lo_r;
          state_nxt = ST_CHK;
        end
      end
      ST_BIN: begin
        if (holds) begin
          done_loc = 1'b1;
          done_hit = 1'b1;
          done_idx = idx_r;
        end else begin
          if (t_r > rd_end) begin
            lo_nxt = idx_r + IDX_W'(1);
          end else begin
            hi_nxt = idx_r;
          end
          state_nxt = ST_BIN_RD;
        end
      end
      ST_CHK: begin
        done_loc = 1'b1;
        done_hit = holds;
        done_idx = lo_r;
      end
      ST_SEEK: begin
        if (tgt >= $signed(TGT_W'(live_cnt))) begin
          out_valid_nxt = 1'b1;
          out_tgt_nxt   = fin_r;
          state_nxt     = ST_IDLE;
        end else if (tgt[TGT_W-1]) begin
          out_valid_nxt = 1'b1;
          out_tgt_nxt   = '0;
          state_nxt     = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(tgt);
          state_nxt = ST_SEEK_RD;
        end
      end
      ST_SEEK_RD: begin
        out_valid_nxt = 1'b1;
        out_tgt_nxt   = rd_start;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (done_loc) begin
      hit_nxt = done_hit;
      idx_nxt = done_hit ? done_idx : '0;
      out_found_nxt = done_hit;
      out_idx_nxt   = done_hit ? done_idx : '0;
      if (op_r == tiloc_pkg::OP_SEEK) begin
        state_nxt = ST_SEEK;
      end else begin
        out_valid_nxt = 1'b1;
        out_tgt_nxt   = '0;
        state_nxt     = ST_IDLE;
        if (done_hit) begin
          last_nxt     = done_idx;
          last_vld_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_vld_r  <= last_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    t_r         <= t_nxt;
    seek_r      <= seek_nxt;
    ofs_r       <= ofs_nxt;
    fin_r       <= fin_nxt;
    idx_r       <= idx_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    hit_r       <= hit_nxt;
    last_r      <= last_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
    out_tgt_r   <= out_tgt_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_hit_index   = out_idx_r;
  assign out_target_time = out_tgt_r;

endmodule

// ===== sim/tiloc_lookup_watch.sv =====
// ----------------------------------------------------------------------------
// tiloc_lookup_watch
// watches the item, config and result ports of the interval locator, keeps a
// copy of the table and of the remembered hit, works out the lookup answer of
// every accepted item and compares it with the result the core gives back
// ----------------------------------------------------------------------------
module tiloc_lookup_watch (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [10:0]                        cfg_data,
  input  logic                               start,
  input  logic                               busy,
  input  logic [1:0]                         in_op,
  input  logic [9:0]                         in_entry_index,
  input  logic [31:0]                        in_entry_start,
  input  logic [31:0]                        in_entry_end,
  input  logic [31:0]                        in_query_time,
  input  logic                               in_seek_happened,
  input  logic signed [tiloc_pkg::OFS_W-1:0] in_step_offset,
  input  logic                               out_valid,
  input  logic                               out_found,
  input  logic [9:0]                         out_hit_index,
  input  logic [31:0]                        out_target_time,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = tiloc_pkg::DEF_TABLE_DEPTH;
  localparam int TW    = tiloc_pkg::DEF_TIME_WIDTH;
  localparam int IW    = 10;

  typedef struct packed {
    logic        found;
    logic [9:0]  idx;
    logic [TW-1:0] target;
  } answer_t;

  logic [TW-1:0] slot_start [DEPTH];
  logic [TW-1:0] slot_end   [DEPTH];
  int            entry_cnt;
  int            last_hit;
  bit            last_ok;
  answer_t       lookup_answers [$];

  function automatic int live_count();
    return (entry_cnt > DEPTH) ? DEPTH : entry_cnt;
  endfunction

  function automatic bit covers(input int i, input logic [TW-1:0] t);
    return t >= slot_start[i[IW-1:0]] && t <= slot_end[i[IW-1:0]];
  endfunction

  // forward scan from the remembered hit, or binary search when forced
  function automatic bit lookup_entry(input logic [TW-1:0] t, input bit forced,
                                      output int idx);
    int n, lo, hi, mid, i, tail;
    n = live_count();
    idx = 0;
    if (n == 0) return 1'b0;
    tail = n - 1;
    if (t >= slot_end[tail[IW-1:0]]) begin
      idx = tail;
      return 1'b1;
    end
    if (last_ok && !forced) begin
      for (i = last_hit; i < n; i++) begin
        if (covers(i, t)) begin
          idx = i;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (covers(mid, t)) begin
        lo = mid;
        break;
      end else if (t > slot_end[mid[IW-1:0]]) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (covers(lo, t)) begin
      idx = lo;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic answer_t answer_item();
    answer_t a;
    int      idx, tgt, n, tail;
    bit      hit;
    a    = '0;
    idx  = 0;
    hit  = 1'b0;
    n    = live_count();
    tail = n - 1;
    case (in_op)
      tiloc_pkg::OP_WRITE: begin
        slot_start[in_entry_index] = in_entry_start;
        slot_end[in_entry_index]   = in_entry_end;
      end
      tiloc_pkg::OP_LOCATE: begin
        hit = lookup_entry(in_query_time, in_seek_happened, idx);
        if (hit) begin
          last_hit = idx;
          last_ok  = 1'b1;
        end
      end
      tiloc_pkg::OP_SEEK: begin
        hit = lookup_entry(in_query_time, 1'b1, idx);
        tgt = (hit ? idx : -1) + int'(in_step_offset);
        if (tgt >= n) a.target = (n == 0) ? '0 : slot_end[tail[IW-1:0]];
        else if (tgt >= 0) a.target = slot_start[tgt[IW-1:0]];
      end
      default: ;
    endcase
    a.found = hit;
    a.idx   = hit ? idx[9:0] : '0;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst_n) begin
      lookup_answers.delete();
      entry_cnt = 0;
      last_hit  = 0;
      last_ok   = 1'b0;
    end else begin
      // a result is always for an item taken at an earlier edge
      if (out_valid) begin
        got = '{out_found, out_hit_index, out_target_time};
        if (lookup_answers.size() == 0) begin
          $error("result with no item outstanding: found %0d hit_index %0d target_time %0h",
                 got.found, got.idx, got.target);
          fail_count++;
        end else begin
          want = lookup_answers.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fail_count++;
          end
          if (got.idx !== want.idx) begin
            $error("hit_index: expected %0d, got %0d", want.idx, got.idx);
            fail_count++;
          end
          if (got.target !== want.target) begin
            $error("target_time: expected %0h, got %0h", want.target, got.target);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) entry_cnt = int'(cfg_data);
      if (start && !busy) lookup_answers.push_back(answer_item());
    end
    pending <= lookup_answers.size();
  end

endmodule

// ===== sim/timed_interval_locator_core_tb.sv =====
// ----------------------------------------------------------------------------
// timed_interval_locator_core_tb
// drives write, locate, seek and unused-op items into the interval locator
// with random gaps, loads sorted tables of many sizes (a 160-entry one
// included), runs a count above the table depth, changes the entry count
// between phases and leaves checking to the watcher
// ----------------------------------------------------------------------------
module timed_interval_locator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = tiloc_pkg::DEF_TABLE_DEPTH;
  localparam int TW    = tiloc_pkg::DEF_TIME_WIDTH;
  localparam int OFS_W = tiloc_pkg::OFS_W;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  // op code the core leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // lookups in the random part
  localparam int RANDOM_QUERIES = 600;
  // size of the one large table in the random part
  localparam int BIG_TABLE = 160;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CNT_W-1:0]        cfg_data;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_op;
  logic [IDX_W-1:0]        in_entry_index;
  logic [TW-1:0]           in_entry_start;
  logic [TW-1:0]           in_entry_end;
  logic [TW-1:0]           in_query_time;
  logic                    in_seek_happened;
  logic signed [OFS_W-1:0] in_step_offset;
  logic                    out_valid;
  logic                    out_found;
  logic [IDX_W-1:0]        out_hit_index;
  logic [TW-1:0]           out_target_time;
  int                      fail_count;
  int                      pending;

  // copy of the loaded intervals, used to aim query times and to rewrite slots
  logic [TW-1:0] aim_lo [DEPTH];
  logic [TW-1:0] aim_hi [DEPTH];
  int            tab_size;   // slots 0 .. tab_size-1 make up the table
  bit            steady;     // phase without sender gaps
  int            queries;

  timed_interval_locator_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_entry_index   (in_entry_index),
    .in_entry_start   (in_entry_start),
    .in_entry_end     (in_entry_end),
    .in_query_time    (in_query_time),
    .in_seek_happened (in_seek_happened),
    .in_step_offset   (in_step_offset),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_hit_index    (out_hit_index),
    .out_target_time  (out_target_time)
  );

  tiloc_lookup_watch watch (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_entry_index   (in_entry_index),
    .in_entry_start   (in_entry_start),
    .in_entry_end     (in_entry_end),
    .in_query_time    (in_query_time),
    .in_seek_happened (in_seek_happened),
    .in_step_offset   (in_step_offset),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_hit_index    (out_hit_index),
    .out_target_time  (out_target_time),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // the timeout leaves room for the slowest legal run, in which every item is a
  // full forward scan of the largest table plus a long gap
  initial begin
    #5_000_000;
    $display("timed_interval_locator_core_tb: done, errors");
    $finish;
  end

  // present one item and hold it until the core takes it; start stays high
  // so a following item can go out at the very next edge
  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] slot,
                           input logic [TW-1:0] lo, input logic [TW-1:0] hi,
                           input logic [TW-1:0] t, input logic sk,
                           input logic signed [OFS_W-1:0] ofs);
    start            <= 1'b1;
    in_op            <= op;
    in_entry_index   <= slot;
    in_entry_start   <= lo;
    in_entry_end     <= hi;
    in_query_time    <= t;
    in_seek_happened <= sk;
    in_step_offset   <= ofs;
    do @(posedge clk); while (busy);
  endtask

  // unused fields carry random bits
  task automatic put_slot(input int i, input logic [TW-1:0] lo, input logic [TW-1:0] hi);
    aim_lo[i[IDX_W-1:0]] = lo;
    aim_hi[i[IDX_W-1:0]] = hi;
    send_item(tiloc_pkg::OP_WRITE, i[IDX_W-1:0], lo, hi, $urandom, 1'($urandom),
              OFS_W'($urandom));
  endtask

  task automatic locate_at(input logic [TW-1:0] t, input logic sk);
    send_item(tiloc_pkg::OP_LOCATE, IDX_W'($urandom), $urandom, $urandom, t, sk,
              OFS_W'($urandom));
  endtask

  task automatic seek_at(input logic [TW-1:0] t, input logic signed [OFS_W-1:0] ofs);
    send_item(tiloc_pkg::OP_SEEK, IDX_W'($urandom), $urandom, $urandom, t, 1'($urandom),
              ofs);
  endtask

  // mostly back to back, some short gaps, a few long ones
  task automatic sender_pause();
    int r, n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!steady) begin
      if (r >= 97) n = $urandom_range(15, 60);
      else if (r >= 65) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every outstanding item has its result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called with the core idle
  task automatic set_count(input int n);
    cfg_valid <= 1'b1;
    cfg_data  <= n[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // sorted, non-overlapping intervals; scale sets gap and length spread
  task automatic build_table(input int n, input int unsigned scale, input bit top_end);
    longint unsigned room, cur;
    int unsigned     lim;
    logic [TW-1:0]   lo, hi;
    room = longint'(n) * (2 * longint'(scale) + 1);
    lim  = 32'(64'hFFFF_FFFF - room);
    cur  = 64'($urandom_range(0, lim));
    for (int i = 0; i < n; i++) begin
      cur += 64'($urandom_range(0, scale));
      lo = cur[TW-1:0];
      cur += 64'($urandom_range(0, scale));
      hi = cur[TW-1:0];
      cur += 1;
      // last interval may run to the top of the time range
      if (top_end && i == n - 1) hi = '1;
      sender_pause();
      put_slot(i, lo, hi);
    end
    tab_size = n;
  endtask

  // one random item against the current table
  task automatic random_query();
    int               r, k, n, ofs;
    logic [IDX_W-1:0] ks;
    logic [TW-1:0]    t, lo, hi;
    n  = tab_size;
    k  = $urandom_range(0, n - 1);
    ks = k[IDX_W-1:0];
    t  = aim_lo[ks] + $urandom_range(0, aim_hi[ks] - aim_lo[ks]);
    r  = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) ofs = $signed($urandom_range(0, 4095) - 2048);
    else ofs = $urandom_range(0, 2 * n + 4) - n - 2;
    if (r < 40) begin
      locate_at(t, $urandom_range(0, 3) == 0);
    end else if (r < 55) begin
      // just outside an interval: a gap or the neighbor's edge
      locate_at($urandom_range(0, 1) ? aim_hi[ks] + 1 : aim_lo[ks] - 1,
                1'($urandom_range(0, 1)));
    end else if (r < 80) begin
      seek_at($urandom_range(0, 3) == 0 ? $urandom : t, ofs[OFS_W-1:0]);
    end else if (r < 88) begin
      // rewrite a slot: same interval, or random content that breaks the order
      if ($urandom_range(0, 1)) begin
        lo = aim_lo[ks];
        hi = aim_hi[ks];
      end else begin
        lo = $urandom;
        hi = $urandom;
      end
      put_slot(k, lo, hi);
    end else if (r < 93) begin
      send_item(OP_UNUSED, IDX_W'($urandom), $urandom, $urandom, $urandom, 1'($urandom),
                OFS_W'($urandom));
    end else begin
      locate_at($urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int n, nq, cnt, phase;
    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_data         <= '0;
    start            <= 1'b0;
    in_op            <= tiloc_pkg::OP_WRITE;
    in_entry_index   <= '0;
    in_entry_start   <= '0;
    in_entry_end     <= '0;
    in_query_time    <= '0;
    in_seek_happened <= 1'b0;
    in_step_offset   <= '0;
    steady   = 1'b0;
    tab_size = 0;
    queries  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: lookups miss and the finish time is 0
    locate_at(0, 1'b0);
    seek_at('1, 12'sd5);
    seek_at(0, -12'sd1);
    send_item(OP_UNUSED, '1, '1, '1, '1, 1'b1, '1);

    // adjacent entries, a single-point entry, a gap, and a last entry that
    // runs to the top of the time range
    put_slot(0, 0, 9);
    put_slot(1, 10, 10);
    put_slot(2, 20, 29);
    put_slot(3, 40, '1);
    put_slot(DEPTH - 1, '1, '1);   // highest slot, outside the count
    tab_size = 4;
    drain();
    set_count(4);

    locate_at(15, 1'b1);       // gap with no remembered hit: miss
    locate_at(0, 1'b0);        // no remembered hit yet: binary search
    locate_at(25, 1'b0);       // forward scan from the remembered hit
    locate_at(5, 1'b0);        // behind the remembered hit: scan misses
    locate_at(5, 1'b1);        // seek flag forces the binary search
    locate_at('1, 1'b0);       // at the finish time: last index
    seek_at(20, 12'sd1);       // start of the next entry
    seek_at(20, 12'sh7FF);     // far past the count: finish time
    seek_at(20, 12'sh800);     // far below zero: clamps to 0
    seek_at(15, 12'sd1);       // miss counts as index -1
    seek_at(15, 12'sd0);

    // remembered hit now lies past the count
    drain();
    set_count(2);
    locate_at(5, 1'b0);
    locate_at(100, 1'b0);      // past the finish time of the shorter table

    // count above the table depth acts as a full table; only the highest
    // slot and slot 0 get read
    drain();
    set_count((1 << CNT_W) - 1);
    locate_at('1, 1'b0);       // at the finish time: highest slot
    seek_at('1, 12'sd5);       // past the table: finish time
    seek_at('1, 12'sd0);       // start of the highest slot
    seek_at('1, -12'sd1023);   // down to slot 0
    seek_at('1, -12'sd1100);   // below zero: clamps to 0

    // random phases: load a table, set a count, then mixed lookups
    phase = 0;
    while (queries < RANDOM_QUERIES) begin
      phase++;
      if (phase == 2) n = BIG_TABLE;
      else if ($urandom_range(0, 6) == 0) n = $urandom_range(1, 2);
      else n = $urandom_range(3, 48);
      steady = ($urandom_range(0, 3) == 0);
      drain();
      case ($urandom_range(0, 3))
        0: build_table(n, 0, $urandom_range(0, 4) == 0);
        1: build_table(n, 3, $urandom_range(0, 4) == 0);
        2: build_table(n, 200, $urandom_range(0, 4) == 0);
        default: build_table(n, 1 << 20, $urandom_range(0, 4) == 0);
      endcase
      if ($urandom_range(0, 3) == 0) cnt = $urandom_range(0, n);
      else cnt = n;
      drain();
      set_count(cnt);
      nq = $urandom_range(20, 60);
      for (int q = 0; q < nq; q++) begin
        sender_pause();
        random_query();
        // now and then wait for every result before going on
        if ($urandom_range(0, 49) == 0) drain();
      end
      queries += nq;
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("timed_interval_locator_core_tb: done, clean");
    else $display("timed_interval_locator_core_tb: done, errors");
    $finish;
  end

endmodule
